### rtl/core/mer_pkg.sv
// shared constants, types and width helpers for the midpoint ellipse rasterizer
package mer_pkg;

    localparam int unsigned AXIS_W         = 10;
    localparam int unsigned OUT_W          = 10;
    localparam int unsigned COORD_BITS_DEF = 10;
    localparam int unsigned S_TDATA_W      = 8;
    localparam int unsigned M_TDATA_W      = 24;
    localparam int unsigned CFG_IDX_W      = 1;

    localparam logic [AXIS_W-1:0] AXIS_X_RST = 10'd100;
    localparam logic [AXIS_W-1:0] AXIS_Y_RST = 10'd50;

    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Y = 1'b1;

    // second multiplier operand: big enough for (2x+1)^2 and for a squared axis
    function automatic int unsigned f_mul_b_w(input int unsigned cb);
        return ((2 * cb + 2) > (2 * AXIS_W)) ? (2 * cb + 2) : (2 * AXIS_W);
    endfunction

    function automatic int unsigned f_prod_w(input int unsigned cb);
        return 2 * AXIS_W + f_mul_b_w(cb);
    endfunction

    // room for an eight-times product plus sign
    function automatic int unsigned f_dec_w(input int unsigned cb);
        return f_prod_w(cb) + 4;
    endfunction

    typedef enum logic [1:0] {
        BASE_ACC  = 2'd0,
        BASE_ZERO = 2'd1,
        BASE_DEC  = 2'd2
    } t_base;

    typedef enum logic [1:0] {
        SH_0 = 2'd0,
        SH_2 = 2'd1,
        SH_3 = 2'd2
    } t_shift;

    typedef struct packed {
        logic   en;
        t_base  base;
        logic   use_prod;
        t_shift shift;
        logic   neg;
    } t_acc_ctl;

    typedef struct packed {
        logic             valid;
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic             r2;
        logic             fin;
    } t_res;

endpackage

### rtl/core/mer_mac.sv
// shared multiplier with registered product and signed shift-accumulate adder
module mer_mac #(
    parameter int unsigned COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
    input  logic                                                i_clk,
    input  logic                                                i_mul_en,
    input  logic [2*mer_pkg::AXIS_W-1:0]                        i_mul_a,
    input  logic [mer_pkg::f_mul_b_w(COORD_BITS)-1:0]           i_mul_b,
    input  mer_pkg::t_acc_ctl                                   i_ctl,
    input  logic signed [mer_pkg::f_dec_w(COORD_BITS)-1:0]      i_dec,
    input  logic [2*mer_pkg::AXIS_W-1:0]                        i_aux,
    output logic [mer_pkg::f_prod_w(COORD_BITS)-1:0]            o_prod,
    output logic signed [mer_pkg::f_dec_w(COORD_BITS)-1:0]      o_acc
);
    import mer_pkg::*;

    localparam int unsigned PW = f_prod_w(COORD_BITS);
    localparam int unsigned DW = f_dec_w(COORD_BITS);

    logic [PW-1:0]        r_prod;
    logic signed [DW-1:0] r_acc;
    logic signed [DW-1:0] n_acc;
    logic signed [DW-1:0] term_raw;
    logic signed [DW-1:0] term_sh;
    logic signed [DW-1:0] term;
    logic signed [DW-1:0] base;

    always_comb begin
        term_raw = i_ctl.use_prod ? signed'(DW'(r_prod)) : signed'(DW'(i_aux));
        case (i_ctl.shift)
            SH_0:    term_sh = term_raw;
            SH_2:    term_sh = term_raw <<< 2;
            SH_3:    term_sh = term_raw <<< 3;
            default: term_sh = term_raw;
        endcase
        term = i_ctl.neg ? -term_sh : term_sh;
        case (i_ctl.base)
            BASE_ACC:  base = r_acc;
            BASE_ZERO: base = '0;
            BASE_DEC:  base = i_dec;
            default:   base = '0;
        endcase
        n_acc = base + term;
    end

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= i_mul_a * i_mul_b;
        end
        if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

### rtl/core/mer_seq.sv
// step sequencer: point state, decision value and micro-op control of the shared unit
module mer_seq #(
    parameter int unsigned COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_start,
    input  logic                                                i_restart,
    input  logic [mer_pkg::AXIS_W-1:0]                          i_axis_x,
    input  logic [mer_pkg::AXIS_W-1:0]                          i_axis_y,
    input  logic                                                i_take,
    output logic                                                o_ready,
    output mer_pkg::t_res                                       o_res,
    output logic                                                o_mul_en,
    output logic [2*mer_pkg::AXIS_W-1:0]                        o_mul_a,
    output logic [mer_pkg::f_mul_b_w(COORD_BITS)-1:0]           o_mul_b,
    output mer_pkg::t_acc_ctl                                   o_ctl,
    output logic signed [mer_pkg::f_dec_w(COORD_BITS)-1:0]      o_dec,
    output logic [2*mer_pkg::AXIS_W-1:0]                        o_aux,
    input  logic [mer_pkg::f_prod_w(COORD_BITS)-1:0]            i_prod,
    input  logic signed [mer_pkg::f_dec_w(COORD_BITS)-1:0]      i_acc
);
    import mer_pkg::*;

    localparam int unsigned MA = 2 * AXIS_W;
    localparam int unsigned MB = f_mul_b_w(COORD_BITS);
    localparam int unsigned DW = f_dec_w(COORD_BITS);

    typedef enum logic [23:0] {
        ST_IDLE = 24'h000001,
        ST_SQA  = 24'h000002,
        ST_SQB  = 24'h000004,
        ST_SQW  = 24'h000008,
        ST_RS1  = 24'h000010,
        ST_RS2  = 24'h000020,
        ST_C1   = 24'h000040,
        ST_C2   = 24'h000080,
        ST_C3   = 24'h000100,
        ST_R1A  = 24'h000200,
        ST_R1B  = 24'h000400,
        ST_R1C  = 24'h000800,
        ST_S1   = 24'h001000,
        ST_S2   = 24'h002000,
        ST_S3   = 24'h004000,
        ST_S4   = 24'h008000,
        ST_S5   = 24'h010000,
        ST_S6   = 24'h020000,
        ST_S7   = 24'h040000,
        ST_T1   = 24'h080000,
        ST_T2   = 24'h100000,
        ST_T3   = 24'h200000,
        ST_WB   = 24'h400000,
        ST_OUT  = 24'h800000
    } t_state;

    t_state                r_state, n_state;
    logic                  r_restart, n_restart;
    logic [COORD_BITS-1:0] r_x, n_x;
    logic [COORD_BITS-1:0] r_y, n_y;
    logic signed [DW-1:0]  r_dec, n_dec;
    logic                  r_r2, n_r2;
    logic                  r_done, n_done;
    logic                  r_move, n_move;
    logic [MA-1:0]         r_a2, n_a2;
    logic [MA-1:0]         r_b2, n_b2;
    logic [MB-1:0]         r_sq, n_sq;

    logic [COORD_BITS-1:0] x_inc;
    logic [COORD_BITS-1:0] y_dec;
    logic [COORD_BITS:0]   tx;
    logic                  dec_neg;
    logic                  dec_le0;
    logic                  acc_le0;

    always_comb begin
        x_inc   = (r_x == {COORD_BITS{1'b1}}) ? r_x : r_x + COORD_BITS'(1);
        y_dec   = r_y - COORD_BITS'(1);
        tx      = {r_x, 1'b1};
        dec_neg = r_dec[DW-1];
        dec_le0 = dec_neg || (r_dec == '0);
        acc_le0 = i_acc[DW-1] || (i_acc == '0);
    end

    always_comb begin
        n_state   = r_state;
        n_restart = r_restart;
        n_x       = r_x;
        n_y       = r_y;
        n_dec     = r_dec;
        n_r2      = r_r2;
        n_done    = r_done;
        n_move    = r_move;
        n_a2      = r_a2;
        n_b2      = r_b2;
        n_sq      = r_sq;
        o_mul_en  = 1'b0;
        o_mul_a   = '0;
        o_mul_b   = '0;
        o_aux     = '0;
        o_ctl     = '{en: 1'b0, base: BASE_ACC, use_prod: 1'b1, shift: SH_0, neg: 1'b0};

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_restart = i_restart;
                    if (i_restart) begin
                        n_state = ST_SQA;
                    end else if (r_done) begin
                        n_state = ST_OUT;
                    end else if (r_y == '0) begin
                        n_done  = 1'b1;
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_SQA;
                    end
                end
            end
            ST_SQA: begin
                o_mul_en = 1'b1;
                o_mul_a  = MA'(i_axis_x);
                o_mul_b  = MB'(i_axis_x);
                n_state  = ST_SQB;
            end
            ST_SQB: begin
                o_mul_en = 1'b1;
                o_mul_a  = MA'(i_axis_y);
                o_mul_b  = MB'(i_axis_y);
                n_a2     = i_prod[MA-1:0];
                n_state  = ST_SQW;
            end
            ST_SQW: begin
                n_b2     = i_prod[MA-1:0];
                o_mul_en = 1'b1;
                o_mul_a  = r_a2;
                if (r_restart) begin
                    // start value: a2 + 4 b2 - 4 a2 b
                    o_mul_b = MB'(i_axis_y);
                    o_aux   = r_a2;
                    o_ctl   = '{en: 1'b1, base: BASE_ZERO, use_prod: 1'b0, shift: SH_0,
                                neg: 1'b0};
                    n_state = ST_RS1;
                end else begin
                    o_mul_b = MB'(r_y);
                    n_state = ST_C1;
                end
            end
            ST_RS1: begin
                o_aux   = r_b2;
                o_ctl   = '{en: 1'b1, base: BASE_ACC, use_prod: 1'b0, shift: SH_2, neg: 1'b0};
                n_x     = '0;
                n_y     = COORD_BITS'(i_axis_y);
                n_r2    = 1'b0;
                n_state = ST_RS2;
            end
            ST_RS2: begin
                o_ctl   = '{en: 1'b1, base: BASE_ACC, use_prod: 1'b1, shift: SH_2, neg: 1'b1};
                n_state = ST_WB;
            end
            ST_C1: begin
                // region test: b2 x - a2 y <= 0
                o_mul_en = 1'b1;
                o_mul_a  = r_b2;
                o_mul_b  = MB'(r_x);
                o_ctl    = '{en: 1'b1, base: BASE_ZERO, use_prod: 1'b1, shift: SH_0, neg: 1'b1};
                n_state  = ST_C2;
            end
            ST_C2: begin
                o_ctl   = '{en: 1'b1, base: BASE_ACC, use_prod: 1'b1, shift: SH_0, neg: 1'b0};
                n_state = ST_C3;
            end
            ST_C3: begin
                if (!r_r2 && acc_le0) begin
                    n_state = ST_R1A;
                end else if (!r_r2) begin
                    n_state = ST_S1;
                end else begin
                    n_state = ST_T1;
                end
            end
            ST_R1A: begin
                n_x = x_inc;
                if (!dec_neg) begin
                    n_y = y_dec;
                end
                o_mul_en = 1'b1;
                o_mul_a  = r_b2;
                o_mul_b  = MB'(x_inc);
                o_aux    = r_b2;
                o_ctl    = '{en: 1'b1, base: BASE_DEC, use_prod: 1'b0, shift: SH_2, neg: 1'b0};
                n_state  = ST_R1B;
            end
            ST_R1B: begin
                o_mul_en = 1'b1;
                o_mul_a  = r_a2;
                o_mul_b  = MB'(r_y);
                o_ctl    = '{en: 1'b1, base: BASE_ACC, use_prod: 1'b1, shift: SH_3, neg: 1'b0};
                n_state  = dec_neg ? ST_WB : ST_R1C;
            end
            ST_R1C: begin
                o_ctl   = '{en: 1'b1, base: BASE_ACC, use_prod: 1'b1, shift: SH_3, neg: 1'b1};
                n_state = ST_WB;
            end
            ST_S1: begin
                // region switch: b2 (2x+1)^2 + 4 a2 (y-1)^2 - 4 a2 b2
                n_r2     = 1'b1;
                o_mul_en = 1'b1;
                o_mul_a  = MA'(tx);
                o_mul_b  = MB'(tx);
                n_state  = ST_S2;
            end
            ST_S2: begin
                n_sq     = i_prod[MB-1:0];
                o_mul_en = 1'b1;
                o_mul_a  = MA'(y_dec);
                o_mul_b  = MB'(y_dec);
                n_state  = ST_S3;
            end
            ST_S3: begin
                n_sq     = i_prod[MB-1:0];
                o_mul_en = 1'b1;
                o_mul_a  = r_b2;
                o_mul_b  = r_sq;
                n_state  = ST_S4;
            end
            ST_S4: begin
                o_mul_en = 1'b1;
                o_mul_a  = r_a2;
                o_mul_b  = r_sq;
                o_ctl    = '{en: 1'b1, base: BASE_ZERO, use_prod: 1'b1, shift: SH_0, neg: 1'b0};
                n_state  = ST_S5;
            end
            ST_S5: begin
                o_mul_en = 1'b1;
                o_mul_a  = r_a2;
                o_mul_b  = MB'(r_b2);
                o_ctl    = '{en: 1'b1, base: BASE_ACC, use_prod: 1'b1, shift: SH_2, neg: 1'b0};
                n_state  = ST_S6;
            end
            ST_S6: begin
                o_ctl   = '{en: 1'b1, base: BASE_ACC, use_prod: 1'b1, shift: SH_2, neg: 1'b1};
                n_state = ST_S7;
            end
            ST_S7: begin
                n_dec   = i_acc;
                n_state = ST_T1;
            end
            ST_T1: begin
                n_move = dec_le0;
                if (dec_le0) begin
                    n_x = x_inc;
                end
                n_y      = y_dec;
                o_mul_en = 1'b1;
                o_mul_a  = r_a2;
                o_mul_b  = MB'(y_dec);
                o_aux    = r_a2;
                o_ctl    = '{en: 1'b1, base: BASE_DEC, use_prod: 1'b0, shift: SH_2, neg: 1'b0};
                n_state  = ST_T2;
            end
            ST_T2: begin
                o_mul_en = 1'b1;
                o_mul_a  = r_b2;
                o_mul_b  = MB'(r_x);
                o_ctl    = '{en: 1'b1, base: BASE_ACC, use_prod: 1'b1, shift: SH_3, neg: 1'b1};
                n_state  = r_move ? ST_T3 : ST_WB;
            end
            ST_T3: begin
                o_ctl   = '{en: 1'b1, base: BASE_ACC, use_prod: 1'b1, shift: SH_3, neg: 1'b0};
                n_state = ST_WB;
            end
            ST_WB: begin
                n_dec = i_acc;
                if (r_y == '0) begin
                    n_done = 1'b1;
                end else if (r_restart) begin
                    n_done = 1'b0;
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_x     <= '0;
            r_y     <= '0;
            r_dec   <= '0;
            r_r2    <= 1'b0;
            r_done  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_x     <= n_x;
            r_y     <= n_y;
            r_dec   <= n_dec;
            r_r2    <= n_r2;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_restart <= n_restart;
        r_move    <= n_move;
        r_a2      <= n_a2;
        r_b2      <= n_b2;
        r_sq      <= n_sq;
    end

    assign o_ready   = (r_state == ST_IDLE);
    assign o_dec     = r_dec;
    assign o_res.valid = (r_state == ST_OUT);
    assign o_res.x   = OUT_W'(r_x);
    assign o_res.y   = OUT_W'(r_y);
    assign o_res.r2  = r_r2;
    assign o_res.fin = r_done;

endmodule

### rtl/core/midpoint_ellipse_rasterizer.sv
// top level of the midpoint ellipse quadrant generator
//
// Generates the first-quadrant points of an ellipse with the two-region midpoint
// scheme. Write the semi-axes through the config port (index 0 horizontal, index
// 1 vertical, reset 100 and 50), send an item with restart set to load (0, ry),
// then send advance items; each item gives exactly one result with the new point,
// the region flag and finished (on tlast). Once finished, advances return the held
// point unchanged. Axes above 2^COORD_BITS-1 are clamped, and x stops there too.
// One item at a time is in work. Every product comes from the single shared
// multiplier, whose product is registered and feeds the decision accumulator in
// the following cycle; the squared axes are re-formed for every item from the live
// register values. The output register frees the sequencer as soon as a result is
// loaded, so the next item is taken while it waits downstream.
module midpoint_ellipse_rasterizer #(
    parameter int unsigned COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [mer_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [mer_pkg::AXIS_W-1:0]        i_cfg_data,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mer_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // [0] restart, [7:1] zero
    // result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mer_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // [9:0] point_x, [19:10]
                                                             // point_y, [20] in_region_two,
                                                             // [23:21] zero
    output logic                              m_axis_tlast   // finished
);
    import mer_pkg::*;

    localparam int unsigned MA = 2 * AXIS_W;
    localparam int unsigned MB = f_mul_b_w(COORD_BITS);
    localparam int unsigned PW = f_prod_w(COORD_BITS);
    localparam int unsigned DW = f_dec_w(COORD_BITS);
    // largest axis the coordinates can hold
    localparam int unsigned SAT_MAX = (COORD_BITS < AXIS_W) ? ((2 ** COORD_BITS) - 1)
                                                            : ((2 ** AXIS_W) - 1);
    localparam int unsigned PAD_W = M_TDATA_W - 2 * OUT_W - 1;

    // config registers
    logic [AXIS_W-1:0] r_axis_x;
    logic [AXIS_W-1:0] r_axis_y;
    logic [AXIS_W-1:0] axis_x_sat;
    logic [AXIS_W-1:0] axis_y_sat;

    // sequencer to shared unit
    logic                 mul_en;
    logic [MA-1:0]        mul_a;
    logic [MB-1:0]        mul_b;
    t_acc_ctl             acc_ctl;
    logic signed [DW-1:0] dec;
    logic [MA-1:0]        aux;
    logic [PW-1:0]        prod;
    logic signed [DW-1:0] acc;

    // result handoff
    t_res              res;
    logic              seq_ready;
    logic              take;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_x;
    logic [OUT_W-1:0]  r_out_y;
    logic              r_out_r2;
    logic              r_out_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_x <= AXIS_X_RST;
            r_axis_y <= AXIS_Y_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_AXIS_X: r_axis_x <= i_cfg_data;
                CFG_AXIS_Y: r_axis_y <= i_cfg_data;
            endcase
        end
    end

    // clamp axes to the coordinate range
    assign axis_x_sat = (r_axis_x > AXIS_W'(SAT_MAX)) ? AXIS_W'(SAT_MAX) : r_axis_x;
    assign axis_y_sat = (r_axis_y > AXIS_W'(SAT_MAX)) ? AXIS_W'(SAT_MAX) : r_axis_y;

    assign s_axis_tready = seq_ready;

    mer_seq #(
        .COORD_BITS (COORD_BITS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (s_axis_tvalid && seq_ready),
        .i_restart (s_axis_tdata[0]),
        .i_axis_x  (axis_x_sat),
        .i_axis_y  (axis_y_sat),
        .i_take    (take),
        .o_ready   (seq_ready),
        .o_res     (res),
        .o_mul_en  (mul_en),
        .o_mul_a   (mul_a),
        .o_mul_b   (mul_b),
        .o_ctl     (acc_ctl),
        .o_dec     (dec),
        .o_aux     (aux),
        .i_prod    (prod),
        .i_acc     (acc)
    );

    mer_mac #(
        .COORD_BITS (COORD_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_mul_en (mul_en),
        .i_mul_a  (mul_a),
        .i_mul_b  (mul_b),
        .i_ctl    (acc_ctl),
        .i_dec    (dec),
        .i_aux    (aux),
        .o_prod   (prod),
        .o_acc    (acc)
    );

    // output register: a result moves in when the slot is empty or draining
    assign take = res.valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_x   <= res.x;
            r_out_y   <= res.y;
            r_out_r2  <= res.r2;
            r_out_fin <= res.fin;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_r2, r_out_y, r_out_x};
    assign m_axis_tlast  = r_out_fin;

endmodule

### rtl/core/mer_checker.sv
// port-level checks for the midpoint ellipse rasterizer, bound to the top level
module mer_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [mer_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tlast
);
    import mer_pkg::*;

    // reset empties the output slot
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // an unfinished point never sits on the x axis
    a_fin_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[2*OUT_W-1:OUT_W] != '0)
        else $error("y reached zero without finished");

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
